// File: rtl/hfd_pkg.sv
// Shared types and constants for the Huffman tree byte decoder.
package hfd_pkg;

	localparam int BYTE_W  = 8;
	localparam int CHILD_W = 9;
	localparam int LEN_W   = 24;
	localparam int ENTRY_W = 2 * CHILD_W;

	localparam logic [1:0] REQ_LOAD   = 2'd0;
	localparam logic [1:0] REQ_START  = 2'd1;
	localparam logic [1:0] REQ_DECODE = 2'd2;

	typedef logic [ENTRY_W-1:0] entry_t;

	typedef struct packed {
		logic              re;
		logic [BYTE_W-1:0] raddr;
		logic              we;
		logic [BYTE_W-1:0] waddr;
		entry_t            wdata;
	} mem_req_t;

endpackage

// File: rtl/hfd_node_mem.sv
// Tree node memory: one write port, one read port, registered read data.
module hfd_node_mem #(
	parameter int NUM_NODES = 255
) (
	input  logic              clk,
	input  hfd_pkg::mem_req_t req,
	output hfd_pkg::entry_t   rdata
);

	localparam int AW = (NUM_NODES > 1) ? $clog2(NUM_NODES) : 1;

	hfd_pkg::entry_t mem [NUM_NODES];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr[AW-1:0]] <= req.wdata;
		end
		if (req.re) begin
			rdata <= mem[req.raddr[AW-1:0]];
		end
	end

endmodule

// File: rtl/hfd_walk.sv
// Request decode, bit-serial tree walk, pending result and output register.
module hfd_walk #(
	parameter int NUM_NODES = 255
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [1:0]                   req_type,
	input  logic [hfd_pkg::BYTE_W-1:0]   node_index,
	input  logic [hfd_pkg::CHILD_W-1:0]  child_zero,
	input  logic [hfd_pkg::CHILD_W-1:0]  child_one,
	input  logic [hfd_pkg::LEN_W-1:0]    out_length,
	input  logic [hfd_pkg::BYTE_W-1:0]   src_byte,
	output hfd_pkg::mem_req_t            mem_req,
	input  hfd_pkg::entry_t              rdata,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [hfd_pkg::BYTE_W-1:0]   out_byte,
	output logic                         last_of_item,
	output logic                         expansion_done
);

	localparam logic [hfd_pkg::BYTE_W-1:0] HEAD  = hfd_pkg::BYTE_W'(NUM_NODES - 1);
	localparam logic [hfd_pkg::BYTE_W-1:0] NODES = hfd_pkg::BYTE_W'(NUM_NODES);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_WALK  = 2'd1;
	localparam logic [1:0] ST_FLUSH = 2'd2;

	logic [1:0]                       state_q;
	logic [hfd_pkg::BYTE_W-1:0]       cur_q;
	logic [hfd_pkg::LEN_W-1:0]        left_q;
	logic [2:0]                       bit_q;
	logic [hfd_pkg::BYTE_W-1:0]       src_q;
	logic                             pend_vld_q;
	logic [hfd_pkg::BYTE_W-1:0]       pend_byte_q;
	logic                             pend_done_q;
	logic                             out_vld_q;
	logic [hfd_pkg::BYTE_W-1:0]       out_byte_q;
	logic                             out_last_q;
	logic                             out_done_q;

	logic                             take;
	logic [hfd_pkg::CHILD_W-1:0]      child;
	logic                             is_leaf;
	logic                             node_ok;
	logic [hfd_pkg::BYTE_W-1:0]       next_node;
	logic [hfd_pkg::LEN_W-1:0]        left_dec;
	logic                             left_zero;
	logic                             out_free;
	logic                             stall;
	logic                             adv;
	logic                             last_bit;
	logic                             push;
	logic                             push_last;

	assign in_ready  = (state_q == ST_IDLE);
	assign take      = in_valid && in_ready;
	assign child     = src_q[bit_q] ? rdata[hfd_pkg::ENTRY_W-1:hfd_pkg::CHILD_W]
	                                : rdata[hfd_pkg::CHILD_W-1:0];
	assign is_leaf   = !child[hfd_pkg::CHILD_W-1];
	assign node_ok   = child[hfd_pkg::BYTE_W-1:0] < NODES;
	assign next_node = (is_leaf || !node_ok) ? HEAD : child[hfd_pkg::BYTE_W-1:0];
	assign left_dec  = left_q - hfd_pkg::LEN_W'(1);
	assign left_zero = (left_dec == '0);
	assign out_free  = !out_vld_q || out_ready;
	assign stall     = is_leaf && pend_vld_q && !out_free;
	assign adv       = (state_q == ST_WALK) && !stall;
	assign last_bit  = (bit_q == 3'd7) || (is_leaf && left_zero);
	assign push_last = (state_q == ST_FLUSH) && out_free;
	assign push      = (adv && is_leaf && pend_vld_q) || push_last;

	always_comb begin
		mem_req.re    = (take && req_type == hfd_pkg::REQ_DECODE && left_q != '0)
		             || (adv && !last_bit);
		mem_req.raddr = (state_q == ST_IDLE) ? cur_q : next_node;
		mem_req.we    = take && req_type == hfd_pkg::REQ_LOAD && node_index < NODES;
		mem_req.waddr = node_index;
		mem_req.wdata = {child_one, child_zero};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			cur_q      <= HEAD;
			left_q     <= '0;
			bit_q      <= '0;
			pend_vld_q <= 1'b0;
			out_vld_q  <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (take) begin
						case (req_type)
							hfd_pkg::REQ_START: begin
								left_q <= out_length;
								cur_q  <= HEAD;
							end
							hfd_pkg::REQ_DECODE: begin
								if (left_q != '0) begin
									bit_q   <= '0;
									state_q <= ST_WALK;
								end
							end
							default: begin
							end
						endcase
					end
				end
				ST_WALK: begin
					if (adv) begin
						cur_q <= next_node;
						if (is_leaf) begin
							left_q     <= left_dec;
							pend_vld_q <= 1'b1;
						end
						if (last_bit) begin
							state_q <= (is_leaf || pend_vld_q) ? ST_FLUSH : ST_IDLE;
						end else begin
							bit_q <= bit_q + 3'd1;
						end
					end
				end
				ST_FLUSH: begin
					if (out_free) begin
						pend_vld_q <= 1'b0;
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (push) begin
				out_vld_q <= 1'b1;
			end else if (out_ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && req_type == hfd_pkg::REQ_DECODE) begin
			src_q <= src_byte;
		end
		if (adv && is_leaf) begin
			pend_byte_q <= child[hfd_pkg::BYTE_W-1:0];
			pend_done_q <= left_zero;
		end
		if (push) begin
			out_byte_q <= pend_byte_q;
			out_last_q <= push_last;
			out_done_q <= pend_done_q;
		end
	end

	assign out_valid      = out_vld_q;
	assign out_byte       = out_byte_q;
	assign last_of_item   = out_last_q;
	assign expansion_done = out_done_q;

endmodule

// File: rtl/huffman_tree_byte_decoder_top.sv
// Top level of the Huffman tree byte decoder.
//
// Input channel (in_valid/in_ready) takes one request per beat: req_type 0
// writes tree node node_index with child_zero/child_one, 1 sets the expanded
// length from out_length and puts the walk at the head node (NUM_NODES-1),
// 2 decodes src_byte least significant bit first. Output channel
// (out_valid/out_ready) carries one decoded byte per beat with last_of_item
// on the final byte of a request and expansion_done on the byte that ends
// the set length.
// Load and start requests complete on accept and leave in_ready high. A decode
// request issues the first node read on accept, walks at most 8 bits with one
// read of the node memory per bit, and, when it decoded any byte, releases
// its last byte from the pending register in a flush step before in_ready rises
// again. With the length used up it is accepted without a walk.
// Decoded bytes sit one deep in a pending register and then in the output
// register; when the receiver stalls, the walk holds and in_ready stays low
// until the request's bytes are out of the pending register.
// Reset puts the walk at the head with zero length and empties the output.
// Node memory contents are kept only as written by load requests.
module huffman_tree_byte_decoder_top #(
	parameter int NUM_NODES = 255
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [1:0]                   req_type,
	input  logic [hfd_pkg::BYTE_W-1:0]   node_index,
	input  logic [hfd_pkg::CHILD_W-1:0]  child_zero,
	input  logic [hfd_pkg::CHILD_W-1:0]  child_one,
	input  logic [hfd_pkg::LEN_W-1:0]    out_length,
	input  logic [hfd_pkg::BYTE_W-1:0]   src_byte,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [hfd_pkg::BYTE_W-1:0]   out_byte,
	output logic                         last_of_item,
	output logic                         expansion_done
);

	hfd_pkg::mem_req_t mem_req;
	hfd_pkg::entry_t   rdata;

	hfd_node_mem #(
		.NUM_NODES(NUM_NODES)
	) u_mem (
		.clk  (clk),
		.req  (mem_req),
		.rdata(rdata)
	);

	hfd_walk #(
		.NUM_NODES(NUM_NODES)
	) u_walk (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.req_type      (req_type),
		.node_index    (node_index),
		.child_zero    (child_zero),
		.child_one     (child_one),
		.out_length    (out_length),
		.src_byte      (src_byte),
		.mem_req       (mem_req),
		.rdata         (rdata),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.out_byte      (out_byte),
		.last_of_item  (last_of_item),
		.expansion_done(expansion_done)
	);

endmodule

// File: rtl/hfd_checker.sv
// Port-level assertions for the Huffman tree byte decoder, with bind.
module hfd_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_valid,
	input logic                         in_ready,
	input logic [1:0]                   req_type,
	input logic                         out_valid,
	input logic                         out_ready,
	input logic [hfd_pkg::BYTE_W-1:0]   out_byte,
	input logic                         last_of_item,
	input logic                         expansion_done
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("output beat dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_byte))
		else $error("output byte changed while stalled");

	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && expansion_done |-> last_of_item)
		else $error("final byte of expansion not marked last of request");

	a_load_start_quick: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (req_type == hfd_pkg::REQ_LOAD ||
		req_type == hfd_pkg::REQ_START) |=> in_ready)
		else $error("load or start request did not complete in one cycle");

endmodule

bind huffman_tree_byte_decoder_top hfd_checker u_hfd_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_valid),
	.in_ready      (in_ready),
	.req_type      (req_type),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.out_byte      (out_byte),
	.last_of_item  (last_of_item),
	.expansion_done(expansion_done)
);

// File: tb/sv/testbench.sv
// Self-checking testbench for the Huffman tree byte decoder: directed walks and random streams.
`timescale 1ns / 1ps

module testbench;

	localparam int NUM_NODES = 255;
	localparam int HEAD_NODE = NUM_NODES - 1;
	localparam int LEAF_LIMIT = 256;
	localparam logic [1:0] REQ_UNUSED = 2'd3;
	localparam logic [hfd_pkg::CHILD_W-1:0] CHILD_MISSING = 9'h1FF;

	typedef struct packed {
		logic [hfd_pkg::BYTE_W-1:0] value;
		logic                       last;
		logic                       done;
	} decoded_t;

	logic                          clk = 1'b0;
	logic                          arst_n;
	logic                          in_valid;
	logic                          in_ready;
	logic [1:0]                    req_type;
	logic [hfd_pkg::BYTE_W-1:0]    node_index;
	logic [hfd_pkg::CHILD_W-1:0]   child_zero;
	logic [hfd_pkg::CHILD_W-1:0]   child_one;
	logic [hfd_pkg::LEN_W-1:0]     out_length;
	logic [hfd_pkg::BYTE_W-1:0]    src_byte;
	logic                          out_valid;
	logic                          out_ready;
	logic [hfd_pkg::BYTE_W-1:0]    out_byte;
	logic                          last_of_item;
	logic                          expansion_done;

	hfd_pkg::entry_t               tree_nodes [NUM_NODES];
	int                            walk_node;
	logic [hfd_pkg::LEN_W-1:0]     bytes_left;
	decoded_t                      decoded_q [$];

	bit                            node_loaded [NUM_NODES];
	int                            loaded_nodes [$];
	int                            send_idle_pct;
	int                            recv_stall_pct;
	int                            fail_count;

	huffman_tree_byte_decoder_top #(
		.NUM_NODES(NUM_NODES)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.req_type(req_type),
		.node_index(node_index),
		.child_zero(child_zero),
		.child_one(child_one),
		.out_length(out_length),
		.src_byte(src_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_byte(out_byte),
		.last_of_item(last_of_item),
		.expansion_done(expansion_done)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic apply_request(input logic [1:0] kind,
			input logic [hfd_pkg::BYTE_W-1:0] idx,
			input logic [hfd_pkg::CHILD_W-1:0] c0, input logic [hfd_pkg::CHILD_W-1:0] c1,
			input logic [hfd_pkg::LEN_W-1:0] len, input logic [hfd_pkg::BYTE_W-1:0] src);
		decoded_t burst [$];
		hfd_pkg::entry_t entry;
		logic [hfd_pkg::CHILD_W-1:0] child;
		case (kind)
			hfd_pkg::REQ_LOAD: begin
				if (idx < NUM_NODES)
					tree_nodes[idx] = {c1, c0};
			end
			hfd_pkg::REQ_START: begin
				bytes_left = len;
				walk_node = HEAD_NODE;
			end
			hfd_pkg::REQ_DECODE: begin
				for (int b = 0; b < 8 && bytes_left != 0; b++) begin
					entry = tree_nodes[walk_node];
					child = src[b] ? entry[hfd_pkg::ENTRY_W-1:hfd_pkg::CHILD_W]
					               : entry[hfd_pkg::CHILD_W-1:0];
					if (child < LEAF_LIMIT) begin
						bytes_left = bytes_left - 1'b1;
						burst.push_back('{child[hfd_pkg::BYTE_W-1:0], 1'b0,
							bytes_left == 0});
						walk_node = HEAD_NODE;
					end else if (child - LEAF_LIMIT < NUM_NODES) begin
						walk_node = child - LEAF_LIMIT;
					end else begin
						walk_node = HEAD_NODE;
					end
				end
				if (burst.size() > 0)
					burst[burst.size()-1].last = 1'b1;
				foreach (burst[i])
					decoded_q.push_back(burst[i]);
			end
			default: ;
		endcase
	endtask

	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready)
			apply_request(req_type, node_index, child_zero, child_one, out_length, src_byte);
	end

	always @(posedge clk) begin : check_beats
		decoded_t want;
		if (arst_n && out_valid && out_ready) begin
			if (decoded_q.size() == 0) begin
				$error("out_byte: expected none, actual %02h", out_byte);
				fail_count++;
			end else begin
				want = decoded_q.pop_front();
				if (out_byte !== want.value) begin
					$error("out_byte: expected %02h, actual %02h", want.value, out_byte);
					fail_count++;
				end
				if (last_of_item !== want.last) begin
					$error("last_of_item: expected %0b, actual %0b", want.last, last_of_item);
					fail_count++;
				end
				if (expansion_done !== want.done) begin
					$error("expansion_done: expected %0b, actual %0b", want.done,
						expansion_done);
					fail_count++;
				end
			end
		end
	end

	always @(posedge clk)
		out_ready <= ($urandom_range(99) >= recv_stall_pct);

	task automatic send_req(input logic [1:0] kind, input logic [hfd_pkg::BYTE_W-1:0] idx,
			input logic [hfd_pkg::CHILD_W-1:0] c0, input logic [hfd_pkg::CHILD_W-1:0] c1,
			input logic [hfd_pkg::LEN_W-1:0] len, input logic [hfd_pkg::BYTE_W-1:0] src);
		int gap;
		gap = 0;
		while ($urandom_range(99) < send_idle_pct && gap < 60)
			gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid   <= 1'b1;
		req_type   <= kind;
		node_index <= idx;
		child_zero <= c0;
		child_one  <= c1;
		out_length <= len;
		src_byte   <= src;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	task automatic load_node(input logic [hfd_pkg::BYTE_W-1:0] idx,
			input logic [hfd_pkg::CHILD_W-1:0] c0, input logic [hfd_pkg::CHILD_W-1:0] c1);
		send_req(hfd_pkg::REQ_LOAD, idx, c0, c1, hfd_pkg::LEN_W'($urandom),
			hfd_pkg::BYTE_W'($urandom));
	endtask

	task automatic start_len(input logic [hfd_pkg::LEN_W-1:0] len);
		send_req(hfd_pkg::REQ_START, hfd_pkg::BYTE_W'($urandom), hfd_pkg::CHILD_W'($urandom),
			hfd_pkg::CHILD_W'($urandom), len, hfd_pkg::BYTE_W'($urandom));
	endtask

	task automatic decode(input logic [hfd_pkg::BYTE_W-1:0] src);
		send_req(hfd_pkg::REQ_DECODE, hfd_pkg::BYTE_W'($urandom), hfd_pkg::CHILD_W'($urandom),
			hfd_pkg::CHILD_W'($urandom), hfd_pkg::LEN_W'($urandom), src);
	endtask

	function automatic void mark_loaded(input int idx);
		if (idx < NUM_NODES && !node_loaded[idx]) begin
			node_loaded[idx] = 1'b1;
			loaded_nodes.push_back(idx);
		end
	endfunction

	function automatic logic [hfd_pkg::CHILD_W-1:0] pick_child();
		int r;
		r = $urandom_range(99);
		if (r < 55)
			return hfd_pkg::CHILD_W'($urandom_range(LEAF_LIMIT - 1));
		else if (r < 97)
			return hfd_pkg::CHILD_W'(LEAF_LIMIT +
				loaded_nodes[$urandom_range(loaded_nodes.size() - 1)]);
		return CHILD_MISSING;
	endfunction

	function automatic logic [hfd_pkg::LEN_W-1:0] pick_len();
		int r;
		r = $urandom_range(99);
		if (r < 10)
			return '0;
		else if (r < 25)
			return hfd_pkg::LEN_W'($urandom);
		return hfd_pkg::LEN_W'($urandom_range(30, 1));
	endfunction

	task automatic build_tree(input int n_new);
		int batch [$];
		mark_loaded(HEAD_NODE);
		batch.push_back(HEAD_NODE);
		while (batch.size() < n_new) begin
			batch.push_back($urandom_range(HEAD_NODE));
			mark_loaded(batch[batch.size()-1]);
		end
		foreach (batch[i])
			load_node(hfd_pkg::BYTE_W'(batch[i]), pick_child(), pick_child());
	endtask

	task automatic test_tree_walk();
		load_node(8'd255, CHILD_MISSING, CHILD_MISSING);
		mark_loaded(HEAD_NODE);
		mark_loaded(0);
		load_node(8'd254, 9'd256, 9'd255);
		load_node(8'd0, 9'd0, 9'd510);
		start_len(24'd20);
		decode(8'hFF);
		decode(8'h00);
		decode(8'hA5);
		decode(8'h5A);
	endtask

	task automatic test_length_edges();
		start_len(24'd0);
		decode(8'hFF);
		start_len(24'd1);
		decode(8'hFF);
		decode(8'h00);
		start_len(24'hFFFFFF);
		decode(8'h55);
		decode(8'hAA);
		send_req(REQ_UNUSED, 8'hFF, 9'h1FF, 9'h1FF, 24'hFFFFFF, 8'hFF);
	endtask

	task automatic test_missing_child();
		load_node(8'd254, 9'd256, CHILD_MISSING);
		start_len(24'd6);
		decode(8'h0F);
		decode(8'hF2);
		load_node(8'd254, 9'd256, 9'd255);
		decode(8'h3C);
	endtask

	task automatic run_random_phase(input int send_pct, input int recv_pct, input int n_items);
		int count;
		int r;
		int idx;
		send_idle_pct  = send_pct;
		recv_stall_pct = recv_pct;
		count = 0;
		while (count < n_items) begin
			if ($urandom_range(3) == 0) begin
				r = $urandom_range(6, 1);
				build_tree(r);
				count += r;
			end
			start_len(pick_len());
			count++;
			repeat ($urandom_range(8, 1)) begin
				r = $urandom_range(99);
				if (r < 8) begin
					idx = $urandom_range(255);
					mark_loaded(idx);
					load_node(hfd_pkg::BYTE_W'(idx), pick_child(), pick_child());
					count++;
				end else if (r < 12) begin
					send_req(REQ_UNUSED, hfd_pkg::BYTE_W'($urandom),
						hfd_pkg::CHILD_W'($urandom), hfd_pkg::CHILD_W'($urandom),
						hfd_pkg::LEN_W'($urandom), hfd_pkg::BYTE_W'($urandom));
				end else begin
					decode(hfd_pkg::BYTE_W'($urandom));
					count++;
				end
			end
		end
	endtask

	task automatic test_random_streams();
		run_random_phase(0, 0, 16);
		run_random_phase(80, 0, 16);
		run_random_phase(0, 80, 16);
		run_random_phase(16, 16, 16);
	endtask

	initial begin
		#5_000_000;
		$display("TEST FAILED");
		$finish;
	end

	initial begin
		fail_count     = 0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		walk_node      = HEAD_NODE;
		bytes_left     = '0;
		arst_n         <= 1'b0;
		in_valid       <= 1'b0;
		req_type       <= hfd_pkg::REQ_LOAD;
		node_index     <= '0;
		child_zero     <= '0;
		child_one      <= '0;
		out_length     <= '0;
		src_byte       <= '0;
		out_ready      <= 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_tree_walk();
		test_length_edges();
		test_missing_child();
		test_random_streams();

		in_valid <= 1'b0;
		@(posedge clk);
		while (decoded_q.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (fail_count == 0 && decoded_q.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
